FILE: hw/rtl/swr_pkg.sv
// Shared types and constants for the sliding window receiver.
package swr_pkg;

    localparam int WINDOW_SLOTS = 8;
    localparam int MAX_PAYLOAD  = 1024;
    localparam int SLOT_W       = $clog2(WINDOW_SLOTS);
    localparam int QDEPTH       = WINDOW_SLOTS + 1;
    localparam int QIDX_W       = $clog2(QDEPTH + 1);

    localparam logic [2:0] CMD_SYN     = 3'd0;
    localparam logic [2:0] CMD_FIN     = 3'd1;
    localparam logic [2:0] CMD_DATA    = 3'd2;
    localparam logic [2:0] CMD_RST     = 3'd3;
    localparam logic [2:0] CMD_ACK     = 3'd4;
    localparam logic [2:0] CMD_TIMEOUT = 3'd5;

    localparam logic [2:0] KIND_DELIVER_IN   = 3'd0;
    localparam logic [2:0] KIND_DELIVER_SLOT = 3'd1;
    localparam logic [2:0] KIND_ACK          = 3'd2;
    localparam logic [2:0] KIND_ACK_REPEAT   = 3'd3;
    localparam logic [2:0] KIND_RST_ABORT    = 3'd4;
    localparam logic [2:0] KIND_TMO_ABORT    = 3'd5;
    localparam logic [2:0] KIND_FINISHED     = 3'd6;
    localparam logic [2:0] KIND_STORE        = 3'd7;

    localparam logic [1:0] REG_TIMEOUT_BASE = 2'd0;
    localparam logic [1:0] REG_MAX_TIMEOUTS = 2'd1;
    localparam logic [1:0] REG_MAX_RESETS   = 2'd2;

    localparam logic [15:0] TIMEOUT_BASE_RST = 16'd1000;
    localparam logic [7:0]  MAX_TIMEOUTS_RST = 8'd10;
    localparam logic [7:0]  MAX_RESETS_RST   = 8'd10;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  slot;
        logic [31:0] seg_seq;
        logic [10:0] seg_len;
        logic [31:0] ack_value;
    } result_t;

    typedef struct packed {
        logic start;
        logic done;
    } div_ctl_t;

endpackage

FILE: hw/rtl/swr_div.sv
// Bit-serial restoring divider, 32-bit dividend by 16-bit divisor.
module swr_div
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [31:0]              dividend,
    input  logic [15:0]              divisor,
    output swr_pkg::div_ctl_t        status,
    output logic [31:0]              quotient
);

    logic [15:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] shifted;
    logic        ge;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[31]};
        ge        = (shifted >= {1'b0, dvs_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = (divisor == 16'd0) ? 16'd1 : divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 16'(shifted - {1'b0, dvs_reg}) : shifted[15:0];
            quo_next = {quo_reg[30:0], ge};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign status.start = start;
    assign status.done  = done_reg;
    assign quotient     = quo_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("divider done without run");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg) else $error("divider failed to start");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg <= 6'd31) else $error("divider count overrun");

endmodule

FILE: hw/rtl/sliding_window_receiver.sv
// Sliding window receiver: event sequencer, slot table and result queue.
//
//  channel | signals                                   | direction
//  in      | in_valid, in_stall, cmd, seq_num, payload_len | item in
//  out     | out_valid, out_stall, kind..last          | result beats out
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register writes
//
// An event passes a dispatch state, then one scan of the slots per pass
// (data) or a run in the divider (timeout while connected), then a finish
// state and a drain that gives one result beat per queued result.
// in_stall is high from acceptance until the last result beat is taken, or until the finish state if there is none.
// Reset clears all slots at once; no clearing pass.
module sliding_window_receiver
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [31:0] seq_num,
    input  logic [10:0] payload_len,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [2:0]  slot,
    output logic [31:0] seg_seq,
    output logic [10:0] seg_len,
    output logic [31:0] ack_value,
    output logic [3:0]  window,
    output logic [31:0] timeout_now,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int SW = swr_pkg::SLOT_W;
    localparam int QW = swr_pkg::QIDX_W;
    localparam logic [SW-1:0] LAST_IDX = SW'(swr_pkg::WINDOW_SLOTS - 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DISP  = 7'b0000010,
        ST_SCANI = 7'b0000100,
        ST_SCANO = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_FIN   = 7'b0100000,
        ST_DRAIN = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] tbase_reg, tbase_next;
    logic [7:0]  maxt_reg, maxt_next;
    logic [7:0]  maxr_reg, maxr_next;

    logic [31:0] slot_seq_reg [swr_pkg::WINDOW_SLOTS];
    logic [10:0] slot_len_mem [swr_pkg::WINDOW_SLOTS];
    logic [31:0] ack_reg, ack_next;
    logic [31:0] prev_reg, prev_next;
    logic [3:0]  free_reg, free_next;
    logic [31:0] tv_reg, tv_next;
    logic [7:0]  ttally_reg, ttally_next;
    logic [7:0]  rtally_reg, rtally_next;
    logic        conn_reg, conn_next;
    logic        closing_reg, closing_next;
    logic        halted_reg, halted_next;

    logic [2:0]  cmd_reg;
    logic [31:0] seq_reg;
    logic [10:0] len_reg;

    logic [SW-1:0] idx_reg, idx_next;
    logic          again_reg, again_next;
    logic          found_reg, found_next;
    logic          hasfree_reg, hasfree_next;
    logic [SW-1:0] fidx_reg, fidx_next;

    swr_pkg::result_t q_mem [swr_pkg::QDEPTH];
    logic [QW-1:0]    qcnt_reg, qcnt_next;
    logic [QW-1:0]    rd_reg, rd_next;
    logic             q_we;
    swr_pkg::result_t q_wdata;

    logic                   slot_clr;
    logic                   slot_wr;
    logic [SW-1:0]          slot_wr_idx;

    logic                   div_start;
    swr_pkg::div_ctl_t      div_status;
    logic [31:0]            div_quo;

    logic        in_acc;
    logic        out_acc;
    logic [31:0] cur_seq;
    logic [10:0] cur_len;
    logic [32:0] tv_sum;
    logic [8:0]  tally_sum;
    logic [7:0]  tally_new;
    logic [31:0] new_ack;
    logic [10:0] len_clamped;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign cur_seq = slot_seq_reg[idx_reg];
    assign cur_len = slot_len_mem[idx_reg];
    assign tv_sum  = {1'b0, tv_reg} + {2'b0, tv_reg[31:1]};
    assign tally_sum = {1'b0, ttally_reg} + {1'b0, div_quo[7:0]};
    assign tally_new = (div_quo >= 32'd255 || tally_sum >= 9'd255) ? 8'd255 : tally_sum[7:0];
    assign len_clamped = (payload_len > 11'(swr_pkg::MAX_PAYLOAD))
                         ? 11'(swr_pkg::MAX_PAYLOAD) : payload_len;

    swr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (tv_next),
        .divisor  (tbase_reg),
        .status   (div_status),
        .quotient (div_quo)
    );

    always_comb
    begin
        tbase_next = tbase_reg;
        maxt_next  = maxt_reg;
        maxr_next  = maxr_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                swr_pkg::REG_TIMEOUT_BASE: tbase_next = cfg_data;
                swr_pkg::REG_MAX_TIMEOUTS: maxt_next  = cfg_data[7:0];
                swr_pkg::REG_MAX_RESETS:   maxr_next  = cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ack_next     = ack_reg;
        prev_next    = prev_reg;
        free_next    = free_reg;
        tv_next      = tv_reg;
        ttally_next  = ttally_reg;
        rtally_next  = rtally_reg;
        conn_next    = conn_reg;
        closing_next = closing_reg;
        halted_next  = halted_reg;
        idx_next     = idx_reg;
        again_next   = again_reg;
        found_next   = found_reg;
        hasfree_next = hasfree_reg;
        fidx_next    = fidx_reg;
        qcnt_next    = qcnt_reg;
        rd_next      = rd_reg;
        q_we         = 1'b0;
        q_wdata      = '0;
        slot_clr     = 1'b0;
        slot_wr      = 1'b0;
        slot_wr_idx  = idx_reg;
        div_start    = 1'b0;
        new_ack      = ack_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    qcnt_next  = '0;
                    rd_next    = '0;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                state_next = ST_FIN;
                if (!halted_reg)
                begin
                    case (cmd_reg)
                        swr_pkg::CMD_SYN, swr_pkg::CMD_FIN:
                        begin
                            if (cmd_reg == swr_pkg::CMD_SYN)
                            begin
                                conn_next = 1'b1;
                            end
                            else
                            begin
                                ttally_next  = '0;
                                closing_next = 1'b1;
                            end
                            new_ack  = seq_reg + 32'd1;
                            ack_next = new_ack;
                            q_we     = 1'b1;
                            q_wdata.ack_value = new_ack;
                            if (new_ack == prev_reg)
                            begin
                                q_wdata.kind = swr_pkg::KIND_ACK_REPEAT;
                            end
                            else
                            begin
                                q_wdata.kind = swr_pkg::KIND_ACK;
                                prev_next    = new_ack;
                            end
                        end
                        swr_pkg::CMD_DATA:
                        begin
                            tv_next     = {16'd0, tbase_reg};
                            ttally_next = '0;
                            idx_next    = '0;
                            if (seq_reg == ack_reg)
                            begin
                                new_ack   = ack_reg + {21'd0, len_reg};
                                ack_next  = new_ack;
                                q_we      = 1'b1;
                                q_wdata.kind      = swr_pkg::KIND_DELIVER_IN;
                                q_wdata.seg_seq   = seq_reg;
                                q_wdata.seg_len   = len_reg;
                                q_wdata.ack_value = new_ack;
                                again_next = 1'b0;
                                state_next = ST_SCANI;
                            end
                            else if (free_reg != 4'd0 && seq_reg > ack_reg)
                            begin
                                found_next   = 1'b0;
                                hasfree_next = 1'b0;
                                state_next   = ST_SCANO;
                            end
                        end
                        swr_pkg::CMD_RST:
                        begin
                            ttally_next = '0;
                            rtally_next = (rtally_reg == 8'd255) ? 8'd255 : rtally_reg + 8'd1;
                            if (rtally_reg > maxr_reg)
                            begin
                                halted_next = 1'b1;
                                q_we = 1'b1;
                                q_wdata.kind      = swr_pkg::KIND_RST_ABORT;
                                q_wdata.ack_value = ack_reg;
                            end
                        end
                        swr_pkg::CMD_ACK:
                        begin
                            if (conn_reg)
                            begin
                                q_we = 1'b1;
                                q_wdata.ack_value = ack_reg;
                                if (ack_reg == prev_reg)
                                begin
                                    q_wdata.kind = swr_pkg::KIND_ACK_REPEAT;
                                end
                                else
                                begin
                                    q_wdata.kind = swr_pkg::KIND_ACK;
                                    prev_next    = ack_reg;
                                end
                            end
                        end
                        swr_pkg::CMD_TIMEOUT:
                        begin
                            if (closing_reg)
                            begin
                                ttally_next = (ttally_reg == 8'd255) ? 8'd255 : ttally_reg + 8'd1;
                                if (ttally_reg > maxt_reg)
                                begin
                                    halted_next = 1'b1;
                                    q_we = 1'b1;
                                    q_wdata.kind      = swr_pkg::KIND_FINISHED;
                                    q_wdata.ack_value = ack_reg;
                                end
                            end
                            else if (conn_reg)
                            begin
                                tv_next    = tv_sum[32] ? 32'hFFFF_FFFF : tv_sum[31:0];
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCANI:
            begin
                if (cur_seq != 32'd0)
                begin
                    if (cur_seq < ack_reg)
                    begin
                        slot_clr  = 1'b1;
                        free_next = free_reg + 4'd1;
                    end
                    else if (cur_seq == ack_reg)
                    begin
                        new_ack    = ack_reg + {21'd0, cur_len};
                        ack_next   = new_ack;
                        slot_clr   = 1'b1;
                        free_next  = free_reg + 4'd1;
                        again_next = 1'b1;
                        q_we       = 1'b1;
                        q_wdata.kind      = swr_pkg::KIND_DELIVER_SLOT;
                        q_wdata.slot      = 3'(idx_reg);
                        q_wdata.seg_seq   = cur_seq;
                        q_wdata.seg_len   = cur_len;
                        q_wdata.ack_value = new_ack;
                    end
                end
                idx_next = idx_reg + SW'(1);
                if (idx_reg == LAST_IDX)
                begin
                    idx_next = '0;
                    if (again_next)
                    begin
                        again_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SCANO:
            begin
                if (cur_seq == seq_reg)
                begin
                    found_next = 1'b1;
                end
                if (cur_seq == 32'd0 && !hasfree_reg)
                begin
                    hasfree_next = 1'b1;
                    fidx_next    = idx_reg;
                end
                idx_next = idx_reg + SW'(1);
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_FIN;
                    if (!found_next && hasfree_next)
                    begin
                        slot_wr     = 1'b1;
                        slot_wr_idx = fidx_next;
                        free_next   = free_reg - 4'd1;
                        q_we        = 1'b1;
                        q_wdata.kind      = swr_pkg::KIND_STORE;
                        q_wdata.slot      = 3'(fidx_next);
                        q_wdata.seg_seq   = seq_reg;
                        q_wdata.seg_len   = len_reg;
                        q_wdata.ack_value = ack_reg;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next  = ST_FIN;
                    ttally_next = tally_new;
                    q_we = 1'b1;
                    q_wdata.ack_value = ack_reg;
                    if (tally_new > maxt_reg)
                    begin
                        halted_next  = 1'b1;
                        q_wdata.kind = swr_pkg::KIND_TMO_ABORT;
                    end
                    else if (ack_reg == prev_reg)
                    begin
                        q_wdata.kind = swr_pkg::KIND_ACK_REPEAT;
                    end
                    else
                    begin
                        q_wdata.kind = swr_pkg::KIND_ACK;
                        prev_next    = ack_reg;
                    end
                end
            end
            ST_FIN:
            begin
                rd_next    = '0;
                state_next = (qcnt_reg == '0) ? ST_IDLE : ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (out_acc)
                begin
                    rd_next = rd_reg + QW'(1);
                    if (last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (q_we)
        begin
            qcnt_next = qcnt_reg + QW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            tbase_reg   <= swr_pkg::TIMEOUT_BASE_RST;
            maxt_reg    <= swr_pkg::MAX_TIMEOUTS_RST;
            maxr_reg    <= swr_pkg::MAX_RESETS_RST;
            ack_reg     <= '0;
            prev_reg    <= '0;
            free_reg    <= 4'(swr_pkg::WINDOW_SLOTS);
            tv_reg      <= {17'd0, swr_pkg::TIMEOUT_BASE_RST[15:1]};
            ttally_reg  <= '0;
            rtally_reg  <= '0;
            conn_reg    <= 1'b0;
            closing_reg <= 1'b0;
            halted_reg  <= 1'b0;
            idx_reg     <= '0;
            again_reg   <= 1'b0;
            found_reg   <= 1'b0;
            hasfree_reg <= 1'b0;
            fidx_reg    <= '0;
            qcnt_reg    <= '0;
            rd_reg      <= '0;
            for (int i = 0; i < swr_pkg::WINDOW_SLOTS; i++)
            begin
                slot_seq_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            tbase_reg   <= tbase_next;
            maxt_reg    <= maxt_next;
            maxr_reg    <= maxr_next;
            ack_reg     <= ack_next;
            prev_reg    <= prev_next;
            free_reg    <= free_next;
            tv_reg      <= tv_next;
            ttally_reg  <= ttally_next;
            rtally_reg  <= rtally_next;
            conn_reg    <= conn_next;
            closing_reg <= closing_next;
            halted_reg  <= halted_next;
            idx_reg     <= idx_next;
            again_reg   <= again_next;
            found_reg   <= found_next;
            hasfree_reg <= hasfree_next;
            fidx_reg    <= fidx_next;
            qcnt_reg    <= qcnt_next;
            rd_reg      <= rd_next;
            if (slot_clr)
            begin
                slot_seq_reg[idx_reg] <= '0;
            end
            if (slot_wr)
            begin
                slot_seq_reg[slot_wr_idx] <= seq_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg <= cmd;
            seq_reg <= seq_num;
            len_reg <= len_clamped;
        end
        if (slot_wr)
        begin
            slot_len_mem[slot_wr_idx] <= len_reg;
        end
        if (q_we)
        begin
            q_mem[qcnt_reg] <= q_wdata;
        end
    end

    assign out_valid   = (state_reg == ST_DRAIN);
    assign kind        = q_mem[rd_reg].kind;
    assign slot        = q_mem[rd_reg].slot;
    assign seg_seq     = q_mem[rd_reg].seg_seq;
    assign seg_len     = q_mem[rd_reg].seg_len;
    assign ack_value   = q_mem[rd_reg].ack_value;
    assign window      = free_reg;
    assign timeout_now = tv_reg;
    assign last        = (rd_reg == qcnt_reg - QW'(1));

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qcnt_reg <= QW'(swr_pkg::QDEPTH)) else $error("result queue overflow");
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= 4'(swr_pkg::WINDOW_SLOTS)) else $error("free count out of range");
    a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> in_stall) else $error("accepted a beat without going busy");
    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rd_reg < qcnt_reg)) else $error("beat past end of queue");
    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == ST_DIV)) else $error("stray divider result");

endmodule

FILE: tb/sliding_window_receiver_checker.sv
// Checker for the sliding window receiver: predicts result beats and compares them.
module sliding_window_receiver_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [31:0] seq_num,
    input  logic [10:0] payload_len,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  kind,
    input  logic [2:0]  slot,
    input  logic [31:0] seg_seq,
    input  logic [10:0] seg_len,
    input  logic [31:0] ack_value,
    input  logic [3:0]  window,
    input  logic [31:0] timeout_now,
    input  logic        last,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fails,
    output int          pending
);

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  slot;
        logic [31:0] seg_seq;
        logic [10:0] seg_len;
        logic [31:0] ack_value;
        logic [3:0]  window;
        logic [31:0] timeout_now;
        logic        last;
    } beat_t;

    beat_t       expected_beats[$];
    beat_t       step_beats[$];

    logic [15:0] base_q;
    logic [7:0]  max_tmo_q;
    logic [7:0]  max_rst_q;
    logic [31:0] slot_seq_q[swr_pkg::WINDOW_SLOTS];
    logic [10:0] slot_len_q[swr_pkg::WINDOW_SLOTS];
    logic [31:0] ack_q;
    logic [31:0] prev_ack_q;
    logic [3:0]  free_q;
    logic [31:0] tmo_q;
    logic [7:0]  tmo_tally_q;
    logic [7:0]  rst_tally_q;
    logic        connected_q;
    logic        closing_q;
    logic        halted_q;

    assign pending = expected_beats.size();

    function automatic void add_beat(logic [2:0] k, logic [2:0] s, logic [31:0] sq,
                                     logic [10:0] ln);
        beat_t b;
        b = '0;
        b.kind = k;
        b.slot = s;
        b.seg_seq = sq;
        b.seg_len = ln;
        b.ack_value = ack_q;
        b.timeout_now = tmo_q;
        step_beats.push_back(b);
    endfunction

    function automatic void send_ack();
        if (ack_q == prev_ack_q)
            add_beat(swr_pkg::KIND_ACK_REPEAT, 0, 0, 0);
        else
        begin
            prev_ack_q = ack_q;
            add_beat(swr_pkg::KIND_ACK, 0, 0, 0);
        end
    endfunction

    function automatic void take_data(logic [31:0] sq, logic [10:0] ln);
        logic again;
        logic found;
        logic [31:0] s;
        tmo_q = {16'd0, base_q};
        tmo_tally_q = 0;
        if (sq == ack_q)
        begin
            ack_q = ack_q + {21'd0, ln};
            add_beat(swr_pkg::KIND_DELIVER_IN, 0, sq, ln);
            do
            begin
                again = 0;
                for (int i = 0; i < swr_pkg::WINDOW_SLOTS; i++)
                begin
                    if (slot_seq_q[i] == 0)
                        continue;
                    if (slot_seq_q[i] < ack_q)
                        slot_seq_q[i] = 0;
                    else if (slot_seq_q[i] == ack_q)
                    begin
                        s = slot_seq_q[i];
                        ack_q = ack_q + {21'd0, slot_len_q[i]};
                        slot_seq_q[i] = 0;
                        add_beat(swr_pkg::KIND_DELIVER_SLOT, i[2:0], s, slot_len_q[i]);
                        again = 1;
                    end
                end
            end
            while (again);
        end
        else if (free_q != 0 && sq > ack_q)
        begin
            found = 0;
            for (int i = 0; i < swr_pkg::WINDOW_SLOTS; i++)
                if (slot_seq_q[i] == sq)
                    found = 1;
            if (!found)
            begin
                for (int i = 0; i < swr_pkg::WINDOW_SLOTS; i++)
                begin
                    if (slot_seq_q[i] == 0)
                    begin
                        slot_seq_q[i] = sq;
                        slot_len_q[i] = ln;
                        add_beat(swr_pkg::KIND_STORE, i[2:0], sq, ln);
                        break;
                    end
                end
            end
        end
        free_q = 0;
        for (int i = 0; i < swr_pkg::WINDOW_SLOTS; i++)
            if (slot_seq_q[i] == 0)
                free_q = free_q + 4'd1;
    endfunction

    function automatic void take_timeout();
        logic [32:0] grown;
        logic [31:0] div;
        logic [31:0] add;
        logic [7:0]  old;
        if (closing_q)
        begin
            old = tmo_tally_q;
            if (tmo_tally_q != 8'hFF)
                tmo_tally_q = tmo_tally_q + 8'd1;
            if (old > max_tmo_q)
            begin
                halted_q = 1;
                add_beat(swr_pkg::KIND_FINISHED, 0, 0, 0);
            end
        end
        else if (connected_q)
        begin
            grown = {1'b0, tmo_q} + {2'b0, tmo_q[31:1]};
            tmo_q = grown[32] ? 32'hFFFF_FFFF : grown[31:0];
            div = (base_q == 0) ? 32'd1 : {16'd0, base_q};
            add = tmo_q / div;
            if (add >= 255 || {24'd0, tmo_tally_q} + add >= 255)
                tmo_tally_q = 8'hFF;
            else
                tmo_tally_q = tmo_tally_q + add[7:0];
            if (tmo_tally_q > max_tmo_q)
            begin
                halted_q = 1;
                add_beat(swr_pkg::KIND_TMO_ABORT, 0, 0, 0);
            end
            else
                send_ack();
        end
    endfunction

    function automatic void take_event(logic [2:0] c, logic [31:0] sq, logic [10:0] raw_len);
        logic [10:0] ln;
        logic [7:0]  old;
        ln = (raw_len > swr_pkg::MAX_PAYLOAD) ? 11'(swr_pkg::MAX_PAYLOAD) : raw_len;
        step_beats.delete();
        if (halted_q)
            return;
        case (c)
            swr_pkg::CMD_SYN:
            begin
                connected_q = 1;
                ack_q = sq + 32'd1;
                send_ack();
            end
            swr_pkg::CMD_FIN:
            begin
                tmo_tally_q = 0;
                closing_q = 1;
                ack_q = sq + 32'd1;
                send_ack();
            end
            swr_pkg::CMD_DATA:
                take_data(sq, ln);
            swr_pkg::CMD_RST:
            begin
                old = rst_tally_q;
                tmo_tally_q = 0;
                if (rst_tally_q != 8'hFF)
                    rst_tally_q = rst_tally_q + 8'd1;
                if (old > max_rst_q)
                begin
                    halted_q = 1;
                    add_beat(swr_pkg::KIND_RST_ABORT, 0, 0, 0);
                end
            end
            swr_pkg::CMD_ACK:
                if (connected_q)
                    send_ack();
            swr_pkg::CMD_TIMEOUT:
                take_timeout();
            default: ;
        endcase
        foreach (step_beats[k])
        begin
            step_beats[k].window = free_q;
            step_beats[k].last = (k == step_beats.size() - 1);
            expected_beats.push_back(step_beats[k]);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_q = swr_pkg::TIMEOUT_BASE_RST;
            max_tmo_q = swr_pkg::MAX_TIMEOUTS_RST;
            max_rst_q = swr_pkg::MAX_RESETS_RST;
            for (int i = 0; i < swr_pkg::WINDOW_SLOTS; i++)
            begin
                slot_seq_q[i] = 0;
                slot_len_q[i] = 0;
            end
            ack_q = 0;
            prev_ack_q = 0;
            free_q = 4'(swr_pkg::WINDOW_SLOTS);
            tmo_q = {17'd0, swr_pkg::TIMEOUT_BASE_RST[15:1]};
            tmo_tally_q = 0;
            rst_tally_q = 0;
            connected_q = 0;
            closing_q = 0;
            halted_q = 0;
            fails = 0;
            expected_beats.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    swr_pkg::REG_TIMEOUT_BASE: base_q = cfg_data;
                    swr_pkg::REG_MAX_TIMEOUTS: max_tmo_q = cfg_data[7:0];
                    swr_pkg::REG_MAX_RESETS:   max_rst_q = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                beat_t got;
                got = {kind, slot, seg_seq, seg_len, ack_value, window, timeout_now, last};
                if (expected_beats.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected beat exp none act %h", $time, got);
                end
                else
                begin
                    beat_t want;
                    want = expected_beats.pop_front();
                    if (got !== want)
                    begin
                        fails++;
                        $display({"%0t: beat mismatch exp kind=%0d slot=%0d seq=%h len=%0d",
                                  " ack=%h win=%0d tmo=%h last=%0d"},
                                 $time, want.kind, want.slot, want.seg_seq, want.seg_len,
                                 want.ack_value, want.window, want.timeout_now, want.last);
                        $display({"%0t:               act kind=%0d slot=%0d seq=%h len=%0d",
                                  " ack=%h win=%0d tmo=%h last=%0d"},
                                 $time, got.kind, got.slot, got.seg_seq, got.seg_len,
                                 got.ack_value, got.window, got.timeout_now, got.last);
                    end
                end
            end
            if (in_valid && !in_stall)
                take_event(cmd, seq_num, payload_len);
        end
    end

endmodule

FILE: tb/sliding_window_receiver_tb.sv
// Top of the sliding window receiver testbench: clock, reset, stimulus and verdict.
module sliding_window_receiver_tb;

    localparam int IDLE_LIMIT = 5000;
    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  cmd;
    logic [31:0] seq_num;
    logic [10:0] payload_len;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  kind;
    logic [2:0]  slot;
    logic [31:0] seg_seq;
    logic [10:0] seg_len;
    logic [31:0] ack_value;
    logic [3:0]  window;
    logic [31:0] timeout_now;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    int          fails;
    int          pending;

    logic        calm;
    logic        hold_req;
    logic        hold_done;
    logic        mid_done;
    int          hold_cycles;
    int          quiet_cycles;
    logic [31:0] cursor;
    int          sent;

    sliding_window_receiver dut (.*);
    sliding_window_receiver_checker chk (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            hold_cycles <= 0;
            hold_done   <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            out_stall   <= 1'b1;
            hold_cycles <= 400;
            hold_done   <= 1'b1;
        end
        else if (hold_cycles > 0)
        begin
            out_stall   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= !calm && ($urandom_range(0, 99) < 11);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("sliding_window_receiver regression: fail");
            $finish;
        end
    end

    task automatic send_event(logic [2:0] c, logic [31:0] sq, logic [10:0] ln);
        if (!calm && $urandom_range(0, 99) < 11)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        seq_num <= sq;
        payload_len <= ln;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_burst();
        logic [31:0] seqs[6];
        logic [10:0] lens[6];
        logic [31:0] tmp_s;
        logic [10:0] tmp_l;
        int          n;
        int          j;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
        begin
            lens[i] = ($urandom_range(0, 99) < 5) ? 11'($urandom_range(0, 2047))
                                                  : 11'($urandom_range(1, 200));
            seqs[i] = cursor;
            cursor = cursor + {21'd0, (lens[i] > swr_pkg::MAX_PAYLOAD)
                                      ? 11'(swr_pkg::MAX_PAYLOAD) : lens[i]};
        end
        for (int i = n - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp_s = seqs[i];
            seqs[i] = seqs[j];
            seqs[j] = tmp_s;
            tmp_l = lens[i];
            lens[i] = lens[j];
            lens[j] = tmp_l;
        end
        for (int i = 0; i < n; i++)
        begin
            send_event(swr_pkg::CMD_DATA, seqs[i], lens[i]);
            if ($urandom_range(0, 99) < 10)
                send_event(swr_pkg::CMD_DATA, seqs[i], lens[i]);
        end
    endtask

    initial
    begin
        int pick;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = '0;
        seq_num = '0;
        payload_len = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        calm = 1'b0;
        hold_req = 1'b0;
        mid_done = 1'b0;
        sent = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed
        send_event(swr_pkg::CMD_ACK, 32'd7, 11'd0);
        send_event(swr_pkg::CMD_TIMEOUT, 32'd0, 11'd0);
        send_event(swr_pkg::CMD_DATA, 32'd0, 11'd0);
        send_event(swr_pkg::CMD_SYN, 32'hFFFF_FFFF, 11'd0);
        send_event(swr_pkg::CMD_ACK, 32'd0, 11'd0);
        send_event(swr_pkg::CMD_DATA, 32'd0, 11'd2047);
        for (int k = 1; k <= 9; k++)
            send_event(swr_pkg::CMD_DATA, 32'd1024 + 32'd100 * k, 11'd100);
        send_event(swr_pkg::CMD_DATA, 32'd1124, 11'd100);
        send_event(swr_pkg::CMD_DATA, 32'd5, 11'd1024);
        send_event(swr_pkg::CMD_DATA, 32'd1024, 11'd100);
        send_event(swr_pkg::CMD_ACK, 32'd0, 11'd0);
        send_event(swr_pkg::CMD_TIMEOUT, 32'd0, 11'd0);
        send_event(swr_pkg::CMD_RST, 32'hFFFF_FFFF, 11'd0);
        send_event(CMD_SPARE_LO, 32'hA5A5_5A5A, 11'h7FF);
        send_event(CMD_SPARE_HI, 32'h5A5A_A5A5, 11'h400);
        send_event(swr_pkg::CMD_DATA, 32'd5000, 11'd10);
        send_event(swr_pkg::CMD_SYN, 32'd6000, 11'd0);
        send_event(swr_pkg::CMD_DATA, 32'd6001, 11'd5);
        cursor = 32'd6006;
        drain();

        write_reg(swr_pkg::REG_MAX_RESETS, 16'd254);
        write_reg(swr_pkg::REG_MAX_TIMEOUTS, 16'd254);
        write_reg(swr_pkg::REG_TIMEOUT_BASE, 16'd65535);

        sent = 0;
        while (sent < 500)
        begin
            pick = $urandom_range(0, 99);
            if (sent >= 100 && !hold_req)
                hold_req = 1'b1;
            if (sent >= 250 && !mid_done)
            begin
                drain();
                write_reg(swr_pkg::REG_TIMEOUT_BASE, 16'($urandom_range(500, 65535)));
                write_reg(swr_pkg::REG_MAX_TIMEOUTS, 16'($urandom_range(100, 254)));
                mid_done = 1'b1;
            end
            calm = (sent >= 300 && sent < 380);
            if (pick < 8)
            begin
                cursor = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255)
                                                     : $urandom;
                send_event(swr_pkg::CMD_SYN, cursor, 11'($urandom_range(0, 2047)));
                cursor = cursor + 1;
            end
            else if (pick < 60)
                send_burst();
            else if (pick < 70)
                send_event(swr_pkg::CMD_ACK, $urandom, 11'($urandom_range(0, 2047)));
            else if (pick < 80)
                send_event(swr_pkg::CMD_TIMEOUT, $urandom, 11'($urandom_range(0, 2047)));
            else if (pick < 84)
                send_event(swr_pkg::CMD_RST, $urandom, 11'($urandom_range(0, 2047)));
            else
            begin
                logic [2:0] c;
                c = 3'($urandom_range(0, 7));
                if (c == swr_pkg::CMD_FIN)
                    c = swr_pkg::CMD_DATA;
                send_event(c, $urandom, 11'($urandom_range(0, 2047)));
            end
        end
        calm = 1'b0;
        drain();

        // closing: finish, timeout abort or reset abort
        write_reg(swr_pkg::REG_TIMEOUT_BASE, 16'd2);
        write_reg(swr_pkg::REG_MAX_TIMEOUTS, 16'd0);
        write_reg(swr_pkg::REG_MAX_RESETS, 16'd0);
        case ($urandom_range(0, 2))
            0:
            begin
                send_event(swr_pkg::CMD_FIN, cursor, 11'd0);
                send_event(swr_pkg::CMD_TIMEOUT, 32'd0, 11'd0);
                send_event(swr_pkg::CMD_TIMEOUT, 32'd0, 11'd0);
            end
            1:
            begin
                send_event(swr_pkg::CMD_SYN, cursor, 11'd0);
                send_event(swr_pkg::CMD_DATA, cursor + 1, 11'd1);
                send_event(swr_pkg::CMD_TIMEOUT, 32'd0, 11'd0);
            end
            default:
            begin
                send_event(swr_pkg::CMD_RST, 32'd0, 11'd0);
                send_event(swr_pkg::CMD_RST, 32'd0, 11'd0);
            end
        endcase
        send_event(swr_pkg::CMD_SYN, 32'd1, 11'd0);
        send_event(swr_pkg::CMD_ACK, 32'd1, 11'd0);
        send_event(swr_pkg::CMD_DATA, 32'd2, 11'd4);
        in_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (100) @(posedge clk);
        if (fails == 0)
            $display("sliding_window_receiver regression: pass");
        else
            $display("sliding_window_receiver regression: fail");
        $finish;
    end

endmodule
